@@ sv/infix_precedence_evaluator_unit_assert.svh @@
// Assertion macros used by the checker file of the infix evaluator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef INFIX_PRECEDENCE_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_PRECEDENCE_EVALUATOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define IPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ sv/ipe_pkg.sv @@
// Package of the infix evaluator: widths, operation and status codes.
// Used by every module of the block; depends on nothing.
package ipe_pkg;
   localparam int ValueWidth = 48;
   localparam int StackDepthDefault = 4;
   localparam int FractionBitsDefault = 16;

   typedef enum logic [1:0] {
      OPN_CLEAR = 2'd0, OPN_PUSH_NUM = 2'd1, OPN_PUSH_OP = 2'd2, OPN_EVAL = 2'd3
   } opn_type;

   typedef enum logic [1:0] {
      OPR_ADD = 2'd0, OPR_SUB = 2'd1, OPR_MUL = 2'd2, OPR_DIV = 2'd3
   } opr_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // Command and result between the sequencer and the arithmetic unit.
   typedef struct packed {
      logic                  start;
      logic [1:0]            code;
      logic [ValueWidth-1:0] a;
      logic [ValueWidth-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [ValueWidth-1:0] result;
   } alu_rsp_type;
endpackage

@@ sv/ipe_req_if.sv @@
// Valid/ready channel interfaces for the request and response items.
// Depends on ipe_pkg for the value width.
interface ipe_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic signed [ipe_pkg::ValueWidth-1:0] operand_value;
   logic [1:0]                    operator_code;
   modport source (output valid, operation, operand_value, operator_code, input ready);
   modport sink (input valid, operation, operand_value, operator_code, output ready);
endinterface

interface ipe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [ipe_pkg::ValueWidth-1:0] top_value;
   logic [1:0]                    status;
   modport source (output valid, top_value, status, input ready);
   modport sink (input valid, top_value, status, output ready);
endinterface

@@ sv/ipe_alu.sv @@
// Shared fixed-point arithmetic unit: saturating add and subtract,
// a multiplier over 24-bit digits and a bit-serial divider. Uses ipe_pkg.
module ipe_alu #(
   parameter int FRACTION_BITS = ipe_pkg::FractionBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ipe_pkg::alu_cmd_type cmd,
   output ipe_pkg::alu_rsp_type rsp
);
   localparam int W  = ipe_pkg::ValueWidth;
   localparam int PW = 2 * W;
   localparam int HW = W / 2;
   localparam int NW = W + FRACTION_BITS;
   localparam int CW = $clog2(NW + 1);

   typedef enum logic [4:0] {
      A_IDLE = 5'b00001, A_MUL = 5'b00010, A_DIV = 5'b00100,
      A_SAT = 5'b01000, A_DONE = 5'b10000
   } astate_type;

   astate_type state_ff, state_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic [PW-1:0] acc_ff, acc_in;          // product or quotient magnitude
   logic [W-1:0]  rem_ff, rem_in;
   logic [NW-1:0] num_ff, num_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    part_ff, part_in;
   logic [W-1:0]  res_ff, res_in;

   logic [W-1:0]  mag_a, mag_b;
   logic [W+1:0]  sum;
   logic [HW-1:0] dig_a, dig_b;
   logic [W-1:0]  part_prod;
   logic [W:0]    rem_shift;

   assign mag_a = cmd.a[W-1] ? W'(-cmd.a) : cmd.a;
   assign mag_b = cmd.b[W-1] ? W'(-cmd.b) : cmd.b;
   assign sum = (cmd.code == ipe_pkg::OPR_SUB)
              ? {{2{cmd.a[W-1]}}, cmd.a} - {{2{cmd.b[W-1]}}, cmd.b}
              : {{2{cmd.a[W-1]}}, cmd.a} + {{2{cmd.b[W-1]}}, cmd.b};
   assign dig_a = part_ff[1] ? ua_ff[W-1:HW] : ua_ff[HW-1:0];
   assign dig_b = part_ff[0] ? ub_ff[W-1:HW] : ub_ff[HW-1:0];
   assign part_prod = dig_a * dig_b;
   assign rem_shift = {rem_ff, num_ff[NW-1]};

   always_comb begin
      state_in = state_ff;
      neg_in = neg_ff; ua_in = ua_ff; ub_in = ub_ff; acc_in = acc_ff;
      rem_in = rem_ff; num_in = num_ff; cnt_in = cnt_ff; part_in = part_ff;
      res_in = res_ff;
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               neg_in = cmd.a[W-1] ^ cmd.b[W-1];
               ua_in = mag_a; ub_in = mag_b;
               acc_in = '0; rem_in = '0; part_in = '0;
               num_in = NW'(mag_a) << FRACTION_BITS;
               cnt_in = CW'(NW);
               case (cmd.code)
                  ipe_pkg::OPR_MUL: state_in = A_MUL;
                  ipe_pkg::OPR_DIV: state_in = (mag_b == '0) ? A_DONE : A_DIV;
                  default: begin
                     state_in = A_DONE;
                     if (sum[W+1] && !sum[W-1]) res_in = {1'b1, {(W-1){1'b0}}};
                     else if (!sum[W+1] && sum[W-1]) res_in = {1'b0, {(W-1){1'b1}}};
                     else res_in = sum[W-1:0];
                  end
               endcase
               if (cmd.code == ipe_pkg::OPR_DIV && mag_b == '0) res_in = '0;
            end
         end
         A_MUL: begin
            acc_in = acc_ff + (PW'(part_prod) << (HW * (32'(part_ff[1]) + 32'(part_ff[0]))));
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) state_in = A_SAT;
            else state_in = A_MUL;
            if (part_ff == 2'd3) acc_in = acc_in >> FRACTION_BITS;
         end
         A_DIV: begin
            num_in = num_ff << 1;
            // The remainder stays below the divisor, so it fits in W bits.
            if (rem_shift >= {1'b0, ub_ff}) begin
               rem_in = W'(rem_shift - {1'b0, ub_ff});
               acc_in = {acc_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[W-1:0];
               acc_in = {acc_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = A_SAT;
         end
         A_SAT: begin
            if (neg_ff) begin
               if (acc_ff > PW'({1'b1, {(W-1){1'b0}}})) res_in = {1'b1, {(W-1){1'b0}}};
               else res_in = W'(-acc_ff);
            end else begin
               if (acc_ff > PW'({1'b0, {(W-1){1'b1}}})) res_in = {1'b0, {(W-1){1'b1}}};
               else res_in = acc_ff[W-1:0];
            end
            state_in = A_DONE;
         end
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= A_IDLE;
      else state_ff <= state_in;
      neg_ff <= neg_in; ua_ff <= ua_in; ub_ff <= ub_in; acc_ff <= acc_in;
      rem_ff <= rem_in; num_ff <= num_in; cnt_ff <= cnt_in; part_ff <= part_in;
      res_ff <= res_in;
   end

   assign rsp.done = (state_ff == A_DONE);
   assign rsp.result = res_ff;
endmodule

@@ sv/infix_precedence_evaluator_unit.sv @@
// Top level of the infix evaluator: stacks and the reduction sequencer.
// Depends on ipe_pkg, the channel interfaces and ipe_alu.
//
//   channel | dir | payload
//   req     | in  | operation, operand_value, operator_code
//   rsp     | out | top_value, status
//
// Clear and number push go straight to output; operator push and evaluate
// pass a check state and, per reduction, the shared arithmetic unit: add,
// subtract and division by zero go straight to done, multiply sums digit
// products, divide gets one quotient bit per cycle; req.ready stays low.
// Reset is synchronous and clears both stack counts.
// A result waits in its register while rsp.ready is low.
module infix_precedence_evaluator_unit #(
   parameter int STACK_DEPTH   = ipe_pkg::StackDepthDefault,
   parameter int FRACTION_BITS = ipe_pkg::FractionBitsDefault
) (
   input logic   clock,
   input logic   reset,
   ipe_req_if.sink   req,
   ipe_rsp_if.source rsp
);
   localparam int W  = ipe_pkg::ValueWidth;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_CHECK = 5'b00010, S_ALU = 5'b00100,
      S_WAIT = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [W-1:0]  val_mem [STACK_DEPTH];
   logic [1:0]    opr_mem [STACK_DEPTH];
   logic [CW-1:0] vcnt_ff, vcnt_in, ocnt_ff, ocnt_in;
   logic [1:0]    opn_ff, opn_in, code_ff, code_in, status_ff, status_in;
   logic [W-1:0]  top_ff, top_in;
   ipe_pkg::alu_cmd_type cmd;
   ipe_pkg::alu_rsp_type arsp;
   logic [1:0]    top_op;
   logic          do_reduce;
   logic [AW-1:0] vtop_idx, vsec_idx;

   assign vtop_idx = AW'(vcnt_ff - CW'(1));
   assign vsec_idx = AW'(vcnt_ff - CW'(2));
   assign top_op = opr_mem[AW'(ocnt_ff - CW'(1))];
   assign do_reduce = (ocnt_ff != '0) &&
      ((opn_ff == ipe_pkg::OPN_EVAL) || (top_op[1] >= code_ff[1]));

   assign cmd.start = (state_ff == S_ALU);
   assign cmd.code = top_op;
   assign cmd.a = val_mem[vsec_idx];
   assign cmd.b = val_mem[vtop_idx];

   ipe_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
      .clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp)
   );

   always_comb begin
      state_in = state_ff; vcnt_in = vcnt_ff; ocnt_in = ocnt_ff;
      opn_in = opn_ff; code_in = code_ff; status_in = status_ff; top_in = top_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               opn_in = req.operation; code_in = req.operator_code;
               status_in = ipe_pkg::STATUS_OK;
               case (req.operation)
                  ipe_pkg::OPN_CLEAR: begin
                     vcnt_in = '0; ocnt_in = '0; state_in = S_OUT;
                  end
                  ipe_pkg::OPN_PUSH_NUM: begin
                     if (vcnt_ff >= CW'(STACK_DEPTH)) status_in = ipe_pkg::STATUS_OVERFLOW;
                     else vcnt_in = vcnt_ff + CW'(1);
                     state_in = S_OUT;
                  end
                  default: state_in = S_CHECK;
               endcase
            end
         end
         S_CHECK: begin
            if (do_reduce) begin
               if (vcnt_ff < CW'(2)) begin
                  ocnt_in = ocnt_ff - CW'(1);
                  status_in = ipe_pkg::STATUS_UNDERFLOW;
                  state_in = S_OUT;
               end else state_in = S_ALU;
            end else begin
               if (opn_ff == ipe_pkg::OPN_PUSH_OP) begin
                  if (ocnt_ff >= CW'(STACK_DEPTH)) status_in = ipe_pkg::STATUS_OVERFLOW;
                  else ocnt_in = ocnt_ff + CW'(1);
               end
               state_in = S_OUT;
            end
         end
         S_ALU: state_in = S_WAIT;
         S_WAIT: begin
            if (arsp.done) begin
               ocnt_in = ocnt_ff - CW'(1);
               vcnt_in = vcnt_ff - CW'(1);
               state_in = S_CHECK;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_OUT && state_in == S_OUT)
         top_in = (vcnt_in == '0) ? '0 : val_mem[AW'(vcnt_in - CW'(1))];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid && req.operation == ipe_pkg::OPN_PUSH_NUM
          && vcnt_ff < CW'(STACK_DEPTH))
         val_mem[AW'(vcnt_ff)] <= req.operand_value;
      if (state_ff == S_WAIT && arsp.done) val_mem[vsec_idx] <= arsp.result;
      if (state_ff == S_CHECK && !do_reduce && opn_ff == ipe_pkg::OPN_PUSH_OP
          && ocnt_ff < CW'(STACK_DEPTH))
         opr_mem[AW'(ocnt_ff)] <= code_ff;
   end

   // A pushed number reaches the stack at the same edge that accepts it,
   // so the result top is taken straight from the input item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vcnt_ff <= '0; ocnt_ff <= '0;
      end else begin
         state_ff <= state_in; vcnt_ff <= vcnt_in; ocnt_ff <= ocnt_in;
      end
      opn_ff <= opn_in; code_ff <= code_in; status_ff <= status_in;
      if (state_ff == S_IDLE && req.valid && req.operation == ipe_pkg::OPN_PUSH_NUM
          && vcnt_ff < CW'(STACK_DEPTH))
         top_ff <= req.operand_value;
      else top_ff <= top_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.top_value = top_ff;
   assign rsp.status = status_ff;
endmodule

@@ sv/ipe_checker.sv @@
// Port-level checker for the infix evaluator, bound to the top level.
// Depends on ipe_pkg and the assertion macro header.
`include "infix_precedence_evaluator_unit_assert.svh"
module ipe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);
   `IPE_ASSERT_IMPL(a_no_both, clock, reset, rsp_valid, !req_ready)
   `IPE_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status <= ipe_pkg::STATUS_OVERFLOW)
   `IPE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `IPE_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind infix_precedence_evaluator_unit ipe_checker u_ipe_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status)
);

@@ tb/tb_infix_precedence_evaluator_unit.sv @@
// Testbench of the infix evaluator: a directed table and random expression
// sequences, results checked against the table or a local precedence predictor.
// Depends on ipe_pkg, the channel interfaces and infix_precedence_evaluator_unit.
`timescale 1ns / 100ps

module tb_infix_precedence_evaluator_unit;
   localparam int VW = ipe_pkg::ValueWidth;
   localparam int DEPTH = ipe_pkg::StackDepthDefault;
   localparam int FRAC = ipe_pkg::FractionBitsDefault;
   localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] VAL_ONE = 48'h10000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      ipe_pkg::opn_type opn;
      logic [VW-1:0]    val;
      ipe_pkg::opr_type opr;
      bit               typed;
      logic [VW-1:0]    top;
      logic [1:0]       st;
   } stim_row_type;

   typedef struct {
      logic [VW-1:0] top;
      logic [1:0]    st;
   } eval_result_type;

   logic clock = 1'b0;
   logic reset;
   ipe_req_if req ();
   ipe_rsp_if rsp ();

   infix_precedence_evaluator_unit DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always #6 clock = ~clock;

   // Predictor state.
   logic [VW-1:0]    num_stack [DEPTH];
   ipe_pkg::opr_type opr_stack [DEPTH];
   int               num_count;
   int               opr_count;

   eval_result_type pending_results[$];
   int  fail_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic logic [VW-1:0] clamp(bit neg, logic [127:0] m);
      if (neg) begin
         if (m > {80'b0, VAL_MIN}) return VAL_MIN;
         return -m[VW-1:0];
      end
      if (m > {80'b0, VAL_MAX}) return VAL_MAX;
      return m[VW-1:0];
   endfunction

   function automatic logic [VW-1:0] mag(logic [VW-1:0] v);
      return v[VW-1] ? -v : v;
   endfunction

   function automatic logic [VW-1:0] apply_op(ipe_pkg::opr_type op, logic [VW-1:0] a,
                                              logic [VW-1:0] b);
      logic signed [VW:0] s;
      logic [VW:0]        sm;
      logic [127:0]       m;
      bit                 neg;
      neg = a[VW-1] ^ b[VW-1];
      case (op)
         ipe_pkg::OPR_ADD, ipe_pkg::OPR_SUB: begin
            s = (op == ipe_pkg::OPR_ADD) ? $signed({a[VW-1], a}) + $signed({b[VW-1], b})
                                         : $signed({a[VW-1], a}) - $signed({b[VW-1], b});
            sm = s[VW] ? -s : s;
            return clamp(s[VW], {79'b0, sm});
         end
         ipe_pkg::OPR_MUL: begin
            m = ({80'b0, mag(a)} * {80'b0, mag(b)}) >> FRAC;
            return clamp(neg, m);
         end
         default: begin
            if (mag(b) == 0) return '0;
            m = ({80'b0, mag(a)} << FRAC) / {80'b0, mag(b)};
            return clamp(neg, m);
         end
      endcase
   endfunction

   // Pops one operator and folds the top two numbers; returns 0 on underflow.
   function automatic bit fold_top();
      ipe_pkg::opr_type op;
      opr_count--;
      op = opr_stack[opr_count];
      if (num_count < 2) return 1'b0;
      num_stack[num_count-2] = apply_op(op, num_stack[num_count-2], num_stack[num_count-1]);
      num_count--;
      return 1'b1;
   endfunction

   function automatic eval_result_type evaluate_item(ipe_pkg::opn_type opn,
                                                     logic [VW-1:0] val,
                                                     ipe_pkg::opr_type opr);
      eval_result_type r;
      r.st = ipe_pkg::STATUS_OK;
      case (opn)
         ipe_pkg::OPN_CLEAR: begin
            num_count = 0;
            opr_count = 0;
         end
         ipe_pkg::OPN_PUSH_NUM: begin
            if (num_count >= DEPTH) r.st = ipe_pkg::STATUS_OVERFLOW;
            else begin
               num_stack[num_count] = val;
               num_count++;
            end
         end
         ipe_pkg::OPN_PUSH_OP: begin
            while (opr_count > 0 && opr_stack[opr_count-1][1] >= opr[1]) begin
               if (!fold_top()) begin
                  r.st = ipe_pkg::STATUS_UNDERFLOW;
                  break;
               end
            end
            if (r.st == ipe_pkg::STATUS_OK) begin
               if (opr_count >= DEPTH) r.st = ipe_pkg::STATUS_OVERFLOW;
               else begin
                  opr_stack[opr_count] = opr;
                  opr_count++;
               end
            end
         end
         default: begin
            while (opr_count > 0) begin
               if (!fold_top()) begin
                  r.st = ipe_pkg::STATUS_UNDERFLOW;
                  break;
               end
            end
         end
      endcase
      r.top = (num_count > 0) ? num_stack[num_count-1] : '0;
      return r;
   endfunction

   task automatic send_item(stim_row_type row);
      eval_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid         <= 1'b1;
      req.operation     <= row.opn;
      req.operand_value <= row.val;
      req.operator_code <= row.opr;
      do @(posedge clock); while (!req.ready);
      r = evaluate_item(row.opn, row.val, row.opr);
      if (row.typed) begin
         r.top = row.top;
         r.st  = row.st;
      end
      pending_results.push_back(r);
   endtask

   function automatic logic [VW-1:0] rand_value();
      case ($urandom_range(5))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return {{16{1'b0}}, $urandom()} - 48'h80000000;
         4: return {$urandom_range(7) == 0, 15'b0, $urandom()} >> $urandom_range(20);
         default: return VW'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic stim_row_type rand_row(ipe_pkg::opn_type opn);
      stim_row_type row;
      row.opn = opn;
      row.val = rand_value();
      row.opr = ipe_pkg::opr_type'($urandom_range(3));
      row.typed = 1'b0;
      row.top = '0;
      row.st = ipe_pkg::STATUS_OK;
      return row;
   endfunction

   always @(negedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      eval_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result top=%h status=%0d", $time,
                     rsp.top_value, rsp.status);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp.top_value !== e.top) begin
               $display("%0t: top_value expected %h actual %h", $time, e.top, rsp.top_value);
               fail_count++;
            end
            if (rsp.status !== e.st) begin
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp.status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      stim_row_type directed [25];
      int sent;
      int k;
      int n;
      directed = '{
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_ADD, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 1, '0,
           ipe_pkg::STATUS_UNDERFLOW},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MAX, ipe_pkg::OPR_SUB, 1, VAL_MAX, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MAX, ipe_pkg::OPR_MUL, 1, VAL_MAX, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_ADD, 1, VAL_MAX, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 1, VAL_MAX, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_CLEAR,    VAL_MAX, ipe_pkg::OPR_DIV, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MIN, ipe_pkg::OPR_ADD, 1, VAL_MIN, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MIN, ipe_pkg::OPR_ADD, 1, VAL_MIN, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_ADD, 1, VAL_MIN, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 1, VAL_MIN, ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, '0,      ipe_pkg::OPR_ADD, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_DIV, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 1, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_ONE, ipe_pkg::OPR_ADD, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MIN, ipe_pkg::OPR_ADD, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, VAL_MAX, ipe_pkg::OPR_ADD, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_NUM, 48'h5,   ipe_pkg::OPR_ADD, 1, VAL_MAX,
           ipe_pkg::STATUS_OVERFLOW},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_MUL, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_SUB, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_DIV, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_MUL, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_PUSH_OP,  '0,      ipe_pkg::OPR_ADD, 0, '0,      ipe_pkg::STATUS_OK},
         '{ipe_pkg::OPN_EVAL,     '0,      ipe_pkg::OPR_ADD, 0, '0,      ipe_pkg::STATUS_OK}
      };
      num_count = 0;
      opr_count = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.operation = ipe_pkg::OPN_CLEAR;
      req.operand_value = '0;
      req.operator_code = ipe_pkg::OPR_ADD;
      rsp.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_item(directed[i]);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ((sent * 4) / RANDOM_ITEMS)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         if ($urandom_range(9) < 7) begin
            // An optional clear, then a well-formed expression: number (operator number)* evaluate.
            if ($urandom_range(1)) begin
               send_item(rand_row(ipe_pkg::OPN_CLEAR));
               sent++;
            end
            n = $urandom_range(4);
            send_item(rand_row(ipe_pkg::OPN_PUSH_NUM));
            sent++;
            for (k = 0; k < n; k++) begin
               send_item(rand_row(ipe_pkg::OPN_PUSH_OP));
               send_item(rand_row(ipe_pkg::OPN_PUSH_NUM));
               sent += 2;
            end
            send_item(rand_row(ipe_pkg::OPN_EVAL));
            sent++;
         end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               send_item(rand_row(ipe_pkg::opn_type'($urandom_range(3))));
               sent++;
            end
         end
      end
      @(negedge clock);
      req.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+sv
sv/ipe_pkg.sv
sv/ipe_req_if.sv
sv/ipe_alu.sv
sv/infix_precedence_evaluator_unit.sv
sv/ipe_checker.sv
tb/tb_infix_precedence_evaluator_unit.sv
